/* hw/rtl/dphc_pkg.sv */
package dphc_pkg;

    typedef enum logic [1:0] {
        STATUS_REGULATED = 2'd0,
        STATUS_HOT       = 2'd1,
        STATUS_BAD       = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOG_INIT,
        ST_LOG_SQ,
        ST_LN_MUL,
        ST_LN_SH,
        ST_TERM_DIV,
        ST_DEW_MUL,
        ST_DEW_GO,
        ST_DEW_DIV,
        ST_REG,
        ST_PWR_DIV,
        ST_FIN
    } state_t;

    localparam logic [2:0] CFG_MAX_POWER    = 3'd0;
    localparam logic [2:0] CFG_HOT_LIMIT    = 3'd1;
    localparam logic [2:0] CFG_DEW_MARGIN   = 3'd2;
    localparam logic [2:0] CFG_BAND_HALF    = 3'd3;
    localparam logic [2:0] CFG_BAD_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_ERROR_FLOOR  = 3'd5;
    localparam logic [2:0] CFG_DRIVE_ENABLE = 3'd6;

    localparam int DIV_NW = 40;
    localparam int DIV_DW = 28;
    localparam int DIV_CW = 6;

    localparam logic [DIV_CW-1:0] DIV_ITER_TERM = 6'd36;
    localparam logic [DIV_CW-1:0] DIV_ITER_DEW  = 6'd38;
    localparam logic [DIV_CW-1:0] DIV_ITER_PWR  = 6'd16;

    typedef struct packed {
        logic                start;
        logic [DIV_CW-1:0]   iters;
    } dphc_div_req_t;

    typedef struct packed {
        logic done;
    } dphc_div_rsp_t;

    // log2 in Q16 by repeated squaring; elaboration only
    function automatic logic [19:0] log2_q16_f(input logic [10:0] x);
        logic [3:0]  e;
        logic [63:0] m;
        logic [15:0] frac;
        e = 4'd0;
        frac = 16'd0;
        for (int k = 0; k < 11; k++)
        begin
            if (x[k])
                e = 4'(k);
        end
        m = 64'(x) << (30 - int'(e));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            if (m[31])
            begin
                m = m >> 1;
                frac[15-i] = 1'b1;
            end
        end
        return {e, frac};
    endfunction

    localparam logic [19:0] LOG_1600 = log2_q16_f(11'd1600);

endpackage

/* hw/rtl/dphc_if.sv */
interface dphc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] probe_temp;
    logic [10:0]        humidity;
    logic signed [11:0] outside_temp;

    modport source (output valid, output probe_temp, output humidity, output outside_temp,
                    input ready);
    modport sink (input valid, input probe_temp, input humidity, input outside_temp,
                  output ready);
endinterface

interface dphc_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         heater_power;
    logic               heater_on;
    logic signed [11:0] dew_point;
    logic [1:0]         tick_status;
    logic               short_interval;

    modport source (output valid, output heater_power, output heater_on, output dew_point,
                    output tick_status, output short_interval, input ready);
    modport sink (input valid, input heater_power, input heater_on, input dew_point,
                  input tick_status, input short_interval, output ready);
endinterface

/* hw/rtl/dphc_div.sv */
module dphc_div
    import dphc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dphc_div_req_t     req,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output dphc_div_rsp_t     rsp,
    output logic [DIV_NW-1:0] quot
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_NW-1:0] quot_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              qbit;

    assign trial = {rem_reg, num_reg[DIV_NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CW'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == DIV_CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // left-align so only the requested quotient bits are walked
            num_reg  <= num << (DIV_CW'(DIV_NW) - req.iters);
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[DIV_NW-2:0], 1'b0};
            rem_reg  <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quot_reg <= {quot_reg[DIV_NW-2:0], qbit};
        end
    end

    assign rsp.done = done_reg;
    assign quot     = quot_reg;

endmodule

/* hw/rtl/dew_point_heater_control_top.sv */
// A too-hot or bad-reading tick goes from ST_CHECK straight to ST_FIN; a regulated tick
// also runs the log, ln, Magnus and dew-division states, and ST_PWR_DIV in the band.
// The shared divider, one quotient bit per cycle over 36 + 38 (+ 16) bits, and 16 log
// squaring steps set the pace; a new sample is taken only in ST_IDLE, after ST_FIN.
// Reset: control and config registers at their listed values, heater off, no result pending.
module dew_point_heater_control_top
    import dphc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    dphc_sample_if.sink          sample,
    dphc_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [11:0]          cfg_data
);

    state_t state_reg, state_next;

    logic [7:0]         max_power_reg;
    logic [10:0]        hot_limit_reg;
    logic [7:0]         dew_margin_reg;
    logic [6:0]         band_half_reg;
    logic [2:0]         bad_limit_reg;
    logic signed [11:0] error_floor_reg;
    logic               drive_enable_reg;

    logic               running_reg;
    logic [2:0]         bad_count_reg;
    logic [7:0]         drive_level_reg;
    logic               short_mode_reg;

    logic signed [11:0] p_reg;
    logic [10:0]        hum_reg;
    logic signed [11:0] ot_reg;
    logic [30:0]        m_reg;
    logic [3:0]         e_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         cnt_reg;
    logic signed [23:0] tmul_reg;
    logic signed [51:0] prod_reg;
    logic signed [21:0] lnq_reg;
    logic signed [22:0] g_reg;
    logic signed [39:0] dnum_reg;
    logic [27:0]        dden_reg;
    logic signed [11:0] dew_reg;
    status_t            status_reg;

    logic               out_valid_reg;
    logic [7:0]         out_power_reg;
    logic               out_on_reg;
    logic signed [11:0] out_dew_reg;
    status_t            out_status_reg;
    logic               out_short_reg;

    dphc_div_req_t      div_req;
    dphc_div_rsp_t      div_rsp;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic [DIV_NW-1:0]  div_quot;

    // tick classification
    logic signed [12:0] p_ext;
    logic signed [12:0] hot_ext;
    logic               is_hot;
    logic               is_bad;
    logic [2:0]         bad_inc;

    assign p_ext   = 13'(p_reg);
    assign hot_ext = $signed({2'b00, hot_limit_reg});
    assign is_hot  = running_reg && (p_ext > hot_ext);
    assign is_bad  = (p_reg < error_floor_reg);
    assign bad_inc = (bad_count_reg == 3'd7) ? 3'd7 : bad_count_reg + 3'd1;

    // log2 front end
    logic [10:0] log_x;
    logic [3:0]  log_e;
    logic [30:0] m_init;
    logic [61:0] sq;
    logic [31:0] sq_hi;

    always_comb
    begin
        log_x = (hum_reg == 11'd0) ? 11'd1 : hum_reg;
        log_e = 4'd0;
        for (int k = 0; k < 11; k++)
        begin
            if (log_x[k])
                log_e = 4'(k);
        end
    end

    assign m_init = 31'(log_x) << (5'd30 - {1'b0, log_e});
    assign sq     = 62'(m_reg) * 62'(m_reg);
    assign sq_hi  = sq[61:30];

    // ln and Magnus terms
    logic signed [20:0] ldiff;
    logic signed [51:0] prod_next;
    logic signed [51:0] prod_adj;
    logic signed [23:0] ot_ext;
    logic signed [23:0] tmul_next;
    logic [23:0]        tmag;
    logic signed [18:0] tden;
    logic signed [21:0] termq;
    logic signed [39:0] dnum_next;
    logic signed [27:0] dden_full;
    logic [39:0]        dmag;
    logic signed [11:0] dew_sat;

    assign ldiff     = $signed({1'b0, e_reg, frac_reg}) - $signed({1'b0, LOG_1600});
    assign prod_next = 52'(ldiff) * 52'sd744261118;
    assign prod_adj  = prod_reg + (prod_reg[51] ? 52'sd1073741823 : 52'sd0);
    assign ot_ext    = 24'(ot_reg);
    assign tmul_next = ot_ext * 24'sd3525;
    assign tmag      = tmul_reg[23] ? 24'(-tmul_reg) : 24'(tmul_reg);
    assign tden      = 19'sd97216 + 19'(ot_reg) * 19'sd25;
    assign termq     = ot_reg[11] ? -$signed(22'(div_quot)) : $signed(22'(div_quot));
    assign dnum_next = 40'(g_reg) * 40'sd97216;
    assign dden_full = (28'sd1155072 - 28'(g_reg)) * 28'sd25;
    assign dmag      = dnum_reg[39] ? 40'(-dnum_reg) : 40'(dnum_reg);

    always_comb
    begin
        if (g_reg[22])
            dew_sat = (div_quot >= 40'd2048) ? -12'sd2048 : -$signed(12'(div_quot));
        else
            dew_sat = (div_quot > 40'd2047) ? 12'sd2047 : $signed(12'(div_quot));
    end

    // regulation
    logic signed [13:0] delta;
    logic signed [13:0] b_s;
    logic signed [13:0] db;
    logic               go_full;
    logic               go_prop;
    logic [15:0]        pwr_num;

    assign delta   = 14'(dew_reg) + $signed({6'b0, dew_margin_reg}) - 14'(p_reg);
    assign b_s     = $signed({7'b0, band_half_reg});
    assign db      = delta + b_s;
    assign go_full = (delta > b_s);
    assign go_prop = !go_full && running_reg && (delta >= -b_s);
    assign pwr_num = 16'(max_power_reg) * 16'(db[7:0]);

    logic out_free;
    assign out_free = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (sample.valid) state_next = ST_CHECK;
            ST_CHECK:    state_next = (is_hot || is_bad) ? ST_FIN : ST_LOG_INIT;
            ST_LOG_INIT: state_next = ST_LOG_SQ;
            ST_LOG_SQ:   if (cnt_reg == 4'd15) state_next = ST_LN_MUL;
            ST_LN_MUL:   state_next = ST_LN_SH;
            ST_LN_SH:    state_next = ST_TERM_DIV;
            ST_TERM_DIV: if (div_rsp.done) state_next = ST_DEW_MUL;
            ST_DEW_MUL:  state_next = ST_DEW_GO;
            ST_DEW_GO:   state_next = ST_DEW_DIV;
            ST_DEW_DIV:  if (div_rsp.done) state_next = ST_REG;
            ST_REG:
            begin
                if (go_prop && (band_half_reg != 7'd0))
                    state_next = ST_PWR_DIV;
                else
                    state_next = ST_FIN;
            end
            ST_PWR_DIV:  if (div_rsp.done) state_next = ST_FIN;
            ST_FIN:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        sample.ready  = 1'b0;
        div_req.start = 1'b0;
        div_req.iters = DIV_ITER_TERM;
        div_num       = {4'b0, tmag[22:0], 13'b0};
        div_den       = {10'b0, tden[17:0]};
        unique case (state_reg)
            ST_IDLE:  sample.ready = 1'b1;
            ST_LN_SH: div_req.start = 1'b1;
            ST_DEW_GO:
            begin
                div_req.start = 1'b1;
                div_req.iters = DIV_ITER_DEW;
                div_num       = dmag;
                div_den       = dden_reg;
            end
            ST_REG:
            begin
                div_req.start = go_prop && (band_half_reg != 7'd0);
                div_req.iters = DIV_ITER_PWR;
                div_num       = {24'b0, pwr_num};
                div_den       = {20'b0, band_half_reg, 1'b0};
            end
            default: ;
        endcase
    end

    dphc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .rsp   (div_rsp),
        .quot  (div_quot)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            max_power_reg    <= 8'd255;
            hot_limit_reg    <= 11'd800;
            dew_margin_reg   <= 8'd80;
            band_half_reg    <= 7'd8;
            bad_limit_reg    <= 3'd3;
            error_floor_reg  <= -12'sd1600;
            drive_enable_reg <= 1'b0;
            running_reg      <= 1'b0;
            bad_count_reg    <= 3'd0;
            drive_level_reg  <= 8'd0;
            short_mode_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_POWER:    max_power_reg    <= cfg_data[7:0];
                    CFG_HOT_LIMIT:    hot_limit_reg    <= cfg_data[10:0];
                    CFG_DEW_MARGIN:   dew_margin_reg   <= cfg_data[7:0];
                    CFG_BAND_HALF:    band_half_reg    <= cfg_data[6:0];
                    CFG_BAD_LIMIT:    bad_limit_reg    <= cfg_data[2:0];
                    CFG_ERROR_FLOOR:  error_floor_reg  <= $signed(cfg_data);
                    CFG_DRIVE_ENABLE: drive_enable_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_CHECK:
                begin
                    if (is_hot)
                    begin
                        running_reg    <= 1'b0;
                        short_mode_reg <= 1'b0;
                        if (drive_enable_reg)
                            drive_level_reg <= 8'd0;
                    end
                    else if (is_bad)
                    begin
                        bad_count_reg <= bad_inc;
                        if (running_reg && (bad_inc >= bad_limit_reg))
                        begin
                            running_reg    <= 1'b0;
                            short_mode_reg <= 1'b0;
                            if (drive_enable_reg)
                                drive_level_reg <= 8'd0;
                        end
                    end
                    else
                        bad_count_reg <= 3'd0;
                end
                ST_REG:
                begin
                    if (go_full)
                    begin
                        running_reg    <= 1'b1;
                        short_mode_reg <= 1'b0;
                        if (drive_enable_reg)
                            drive_level_reg <= max_power_reg;
                    end
                    else if (go_prop)
                    begin
                        short_mode_reg <= 1'b1;
                        if (drive_enable_reg && (band_half_reg == 7'd0))
                            drive_level_reg <= max_power_reg;
                    end
                    else if (running_reg)
                    begin
                        running_reg    <= 1'b0;
                        short_mode_reg <= 1'b0;
                        if (drive_enable_reg)
                            drive_level_reg <= 8'd0;
                    end
                end
                ST_PWR_DIV:
                begin
                    if (div_rsp.done && drive_enable_reg)
                        drive_level_reg <= div_quot[7:0];
                end
                default: ;
            endcase

            if ((state_reg == ST_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    p_reg   <= sample.probe_temp;
                    hum_reg <= sample.humidity;
                    ot_reg  <= sample.outside_temp;
                end
            end
            ST_CHECK:
            begin
                dew_reg <= 12'sd0;
                if (is_hot)
                    status_reg <= STATUS_HOT;
                else if (is_bad)
                    status_reg <= STATUS_BAD;
                else
                    status_reg <= STATUS_REGULATED;
            end
            ST_LOG_INIT:
            begin
                m_reg    <= m_init;
                e_reg    <= log_e;
                frac_reg <= 16'd0;
                cnt_reg  <= 4'd0;
                tmul_reg <= tmul_next;
            end
            ST_LOG_SQ:
            begin
                // renormalize when the square reaches two
                if (sq_hi[31])
                    m_reg <= sq_hi[31:1];
                else
                    m_reg <= sq_hi[30:0];
                frac_reg <= {frac_reg[14:0], sq_hi[31]};
                cnt_reg  <= cnt_reg + 4'd1;
            end
            ST_LN_MUL:   prod_reg <= prod_next;
            ST_LN_SH:    lnq_reg <= 22'(prod_adj >>> 30);
            ST_TERM_DIV: if (div_rsp.done) g_reg <= 23'(lnq_reg) + 23'(termq);
            ST_DEW_MUL:
            begin
                dnum_reg <= dnum_next;
                dden_reg <= dden_full[27:0];
            end
            ST_DEW_DIV:  if (div_rsp.done) dew_reg <= dew_sat;
            default: ;
        endcase

        if ((state_reg == ST_FIN) && out_free)
        begin
            out_power_reg  <= drive_enable_reg ? drive_level_reg : 8'd0;
            out_on_reg     <= running_reg;
            out_dew_reg    <= dew_reg;
            out_status_reg <= status_reg;
            out_short_reg  <= short_mode_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.heater_power   = out_power_reg;
    assign result.heater_on      = out_on_reg;
    assign result.dew_point      = out_dew_reg;
    assign result.tick_status    = out_status_reg;
    assign result.short_interval = out_short_reg;

endmodule

/* dv/tb_top.sv */
module tb_top;
    import dphc_pkg::*;

    typedef struct {
        logic signed [11:0] probe;
        logic [10:0]        hum;
        logic signed [11:0] outside;
    } tick_t;

    typedef struct {
        logic [7:0]         power;
        logic               on;
        logic signed [11:0] dew;
        status_t            status;
        logic               short_iv;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = CFG_MAX_POWER;
    logic [11:0] cfg_data = '0;

    dphc_sample_if sample ();
    dphc_result_if result ();

    dew_point_heater_control_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirror of the block's registers and state
    logic [7:0]  m_max_power;
    logic [10:0] m_hot_limit;
    logic [7:0]  m_dew_margin;
    logic [6:0]  m_band_half;
    logic [2:0]  m_bad_limit;
    logic signed [11:0] m_error_floor;
    logic        m_drive_en;
    logic        m_running;
    logic [2:0]  m_bad_count;
    logic [7:0]  m_drive_level;
    logic        m_short;

    tick_t   pending_ticks[$];
    report_t expected_reports[$];
    int      mismatches = 0;
    int      reports_seen = 0;
    int      ticks_sent = 0;
    int      gap_left = 0;
    int      burst_left = 0;
    int      stall_phase = 0;

    function automatic longint log2_fix(longint x);
        int e;
        longint m, fr;
        e = 0;
        fr = 0;
        while (e < 10 && (x >> (e + 1)) != 0)
            e++;
        m = x << (30 - e);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >>> 30;
            if (m >= (64'sd1 <<< 31))
            begin
                m = m >>> 1;
                fr |= 64'sd1 << (15 - i);
            end
        end
        return (longint'(e) << 16) | fr;
    endfunction

    function automatic longint magnus_dew(longint h, longint t);
        longint lnq, termq, g, den, d;
        if (h == 0)
            h = 1;
        lnq = (log2_fix(h) - log2_fix(1600)) * 64'sd744261118 / 64'sd1073741824;
        termq = 64'sd3525 * t * 64'sd8192 / (64'sd97216 + 64'sd25 * t);
        g = lnq + termq;
        den = 64'sd25 * (64'sd1155072 - g);
        if (den <= 0)
            return 2047;
        d = 64'sd97216 * g / den;
        if (d > 2047)
            d = 2047;
        if (d < -2048)
            d = -2048;
        return d;
    endfunction

    function automatic void set_drive(logic [7:0] lvl);
        if (m_drive_en)
            m_drive_level = lvl;
    endfunction

    function automatic void stop_heater();
        set_drive(8'd0);
        m_running = 1'b0;
        m_short = 1'b0;
    endfunction

    function automatic report_t predict_tick(tick_t t);
        report_t r;
        longint p, dew, tgt, d, b;
        p = t.probe;
        dew = 0;
        r.status = STATUS_REGULATED;
        if (m_running && p > longint'(m_hot_limit))
        begin
            stop_heater();
            r.status = STATUS_HOT;
        end
        else if (p < longint'(m_error_floor))
        begin
            if (m_bad_count < 3'd7)
                m_bad_count++;
            if (m_running && m_bad_count >= m_bad_limit)
                stop_heater();
            r.status = STATUS_BAD;
        end
        else
        begin
            b = m_band_half;
            m_bad_count = 3'd0;
            dew = magnus_dew(t.hum, t.outside);
            tgt = dew + longint'(m_dew_margin);
            d = tgt - p;
            if (d > b)
            begin
                set_drive(m_max_power);
                m_running = 1'b1;
                m_short = 1'b0;
            end
            else if (m_running && d >= -b)
            begin
                if (b == 0)
                    set_drive(m_max_power);
                else
                    set_drive(8'(longint'(m_max_power) * (d + b) / (2 * b)));
                m_short = 1'b1;
            end
            else if (m_running)
                stop_heater();
        end
        r.power = m_drive_en ? m_drive_level : 8'd0;
        r.on = m_running;
        r.dew = 12'(dew);
        r.short_iv = m_short;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on report %0d: %s got %0d want %0d", reports_seen, what, got, want);
        mismatches++;
    endtask

    // driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid <= 1'b0;
            sample.probe_temp <= '0;
            sample.humidity <= '0;
            sample.outside_temp <= '0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                expected_reports.push_back(predict_tick(pending_ticks.pop_front()));
                ticks_sent++;
            end
            if (!(sample.valid && !sample.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample.valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    sample.valid <= 1'b1;
                    sample.probe_temp <= pending_ticks[0].probe;
                    sample.humidity <= pending_ticks[0].hum;
                    sample.outside_temp <= pending_ticks[0].outside;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                    end
                    else
                        burst_left--;
                end
                else
                    sample.valid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        report_t w;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch("unexpected report", 0, 0);
                else
                begin
                    w = expected_reports.pop_front();
                    if (result.heater_power !== w.power)
                        report_mismatch("heater_power", result.heater_power, w.power);
                    if (result.heater_on !== w.on)
                        report_mismatch("heater_on", result.heater_on, w.on);
                    if (result.dew_point !== w.dew)
                        report_mismatch("dew_point", result.dew_point, w.dew);
                    if (result.tick_status !== w.status)
                        report_mismatch("tick_status", result.tick_status, w.status);
                    if (result.short_interval !== w.short_iv)
                        report_mismatch("short_interval", result.short_interval,
                                        w.short_iv);
                end
                reports_seen++;
            end
            stall_phase = (stall_phase + 1) % 400;
            if (stall_phase < 150)
                result.ready <= 1'b1;
            else if (stall_phase < 300)
                result.ready <= ($urandom_range(0, 3) != 0);
            else
                result.ready <= ($urandom_range(0, 4) == 0);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MAX_POWER:    m_max_power = val[7:0];
            CFG_HOT_LIMIT:    m_hot_limit = val[10:0];
            CFG_DEW_MARGIN:   m_dew_margin = val[7:0];
            CFG_BAND_HALF:    m_band_half = val[6:0];
            CFG_BAD_LIMIT:    m_bad_limit = val[2:0];
            CFG_ERROR_FLOOR:  m_error_floor = val;
            CFG_DRIVE_ENABLE: m_drive_en = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || sample.valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic add_tick(int p, int h, int o);
        tick_t t;
        t.probe = 12'(p);
        t.hum = 11'(h);
        t.outside = 12'(o);
        pending_ticks.push_back(t);
    endtask

    // heater regulation sequences with random content; some noise mixed in
    task automatic add_random(int n);
        int dw;
        for (int i = 0; i < n; i++)
        begin
            dw = $urandom_range(0, 9);
            if (dw == 0)
                add_tick($urandom_range(0, 4095), $urandom_range(0, 2047),
                         $urandom_range(0, 4095));
            else if (dw == 1)
                add_tick($urandom_range(0, 600) - 2048, $urandom_range(0, 1600),
                         $urandom_range(0, 800) - 300);
            else if (dw == 2)
                add_tick($urandom_range(700, 2047), $urandom_range(0, 1600),
                         $urandom_range(0, 800) - 300);
            else
                add_tick($urandom_range(0, 900) - 300, $urandom_range(0, 1600),
                         $urandom_range(0, 800) - 300);
        end
    endtask

    initial
    begin
        m_max_power = 8'd255;
        m_hot_limit = 11'd800;
        m_dew_margin = 8'd80;
        m_band_half = 7'd8;
        m_bad_limit = 3'd3;
        m_error_floor = -12'sd1600;
        m_drive_en = 1'b0;
        m_running = 1'b0;
        m_bad_count = 3'd0;
        m_drive_level = 8'd0;
        m_short = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // drive disabled: rules still run, power reads zero
        add_tick(0, 800, 200);
        add_tick(2047, 0, -2048);
        add_tick(-2048, 2047, 2047);
        add_random(20);
        drain();

        write_reg(CFG_DRIVE_ENABLE, 12'd1);
        // full power, hot shutoff, hot while off, zero humidity, over 100 percent
        add_tick(0, 1600, 200);
        add_tick(900, 800, 200);
        add_tick(900, 800, 200);
        add_tick(0, 0, -2048);
        add_tick(0, 2047, 2047);
        add_tick(-2048, 1, 0);
        // bad readings up to saturation
        add_tick(0, 1600, 200);
        for (int i = 0; i < 9; i++)
            add_tick(-2048, 800, 0);
        // drift into the band and above it
        add_tick(100, 1600, 0);
        add_tick(80, 800, 0);
        add_tick(0, 800, 0);
        for (int i = 0; i < 12; i++)
            add_tick(-40 + 10 * i, 800, 0);
        drain();

        write_reg(CFG_BAND_HALF, 12'd0);
        write_reg(CFG_BAD_LIMIT, 12'd0);
        add_tick(0, 1600, 200);
        add_tick(-2000, 800, 0);
        add_random(150);
        drain();

        write_reg(CFG_MAX_POWER, 12'd0);
        write_reg(CFG_HOT_LIMIT, 12'd0);
        write_reg(CFG_DEW_MARGIN, 12'd0);
        write_reg(CFG_ERROR_FLOOR, 12'h800);
        write_reg(CFG_BAND_HALF, 12'd127);
        add_random(150);
        drain();

        write_reg(CFG_MAX_POWER, 12'd255);
        write_reg(CFG_HOT_LIMIT, 12'd2047);
        write_reg(CFG_DEW_MARGIN, 12'd255);
        write_reg(CFG_BAD_LIMIT, 12'd7);
        write_reg(CFG_ERROR_FLOOR, 12'd0);
        add_random(150);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_MAX_POWER, 12'($urandom_range(0, 255)));
            write_reg(CFG_HOT_LIMIT, 12'($urandom_range(0, 2047)));
            write_reg(CFG_DEW_MARGIN, 12'($urandom_range(0, 255)));
            write_reg(CFG_BAND_HALF, 12'($urandom_range(0, 127)));
            write_reg(CFG_BAD_LIMIT, 12'($urandom_range(1, 7)));
            write_reg(CFG_ERROR_FLOOR, 12'(-$urandom_range(0, 2048)));
            write_reg(CFG_DRIVE_ENABLE, 12'($urandom_range(0, 1)));
            add_random(110);
            drain();
        end

        $display("covered %0d ticks over register settings from zero to full scale,",
                 ticks_sent);
        $display("with hot, bad-reading and band cases; %0d reports checked", reports_seen);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
